// File: rtl/running_mean_variance_minmax_core_defines.svh
// Assertion macros for the running statistics core.
// Used by the top level only; no other dependencies.
`ifndef RUNNING_MEAN_VARIANCE_MINMAX_CORE_DEFINES_SVH
`define RUNNING_MEAN_VARIANCE_MINMAX_CORE_DEFINES_SVH

// same-cycle implication
`define RMVM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rmvm check failed");

// next-cycle implication
`define RMVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rmvm check failed");

`endif

// File: rtl/rmvm_pkg.sv
// Types and fixed widths shared by the running statistics core.
// No dependencies.
package rmvm_pkg;

   localparam int M2_W        = 56;
   localparam int VAR_W       = 40;
   localparam int DEV_W       = 20;
   localparam int MEAN_W      = 32;
   localparam int ACC_W       = 82;
   localparam int MUL_SAT_BIT = 80;
   localparam int MUL_SHIFT   = 24;
   localparam int REM_W       = 24;
   localparam int STEP_W      = 6;
   localparam int DIV_STEPS   = 56;
   localparam int MUL_STEPS   = 56;
   localparam int SQRT_STEPS  = 20;

   typedef enum logic [1:0] {
      ALU_DIV,
      ALU_MUL,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

endpackage

// File: rtl/rmvm_ifs.sv
// Valid/ready channel interfaces for request and response transfers.
// Depends on nothing; widths follow the core parameters.
interface rmvm_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic signed [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output mode, output sample, input ready);
   modport sink (input valid, input mode, input sample, output ready);
endinterface

interface rmvm_rsp_if #(parameter int SAMPLE_BITS = 16, parameter int COUNT_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic [COUNT_BITS-1:0]         count;
   logic signed [SAMPLE_BITS-1:0] lowest;
   logic signed [SAMPLE_BITS-1:0] highest;
   logic signed [31:0]            mean;
   logic [39:0]                   var_unbiased;
   logic [39:0]                   var_biased;
   logic [19:0]                   dev_unbiased;
   logic [19:0]                   dev_biased;
   logic                          unbiased_valid;
   logic                          overflow;
   modport source (output valid, output count, output lowest, output highest, output mean,
                   output var_unbiased, output var_biased, output dev_unbiased,
                   output dev_biased, output unbiased_valid, output overflow, input ready);
   modport sink (input valid, input count, input lowest, input highest, input mean,
                 input var_unbiased, input var_biased, input dev_unbiased,
                 input dev_biased, input unbiased_valid, input overflow, output ready);
endinterface

// File: rtl/rmvm_alu.sv
// Bit-serial shared unit: restoring divide, shift-add multiply, digit square root.
// Depends on rmvm_pkg.
module rmvm_alu #(
   parameter int OPA_W = 34,
   parameter int COUNT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rmvm_pkg::alu_cmd_type        cmd,
   input  logic [rmvm_pkg::M2_W-1:0]    opnd,
   input  logic [OPA_W-1:0]             mcand,
   input  logic [COUNT_BITS-1:0]        den,
   output logic                         done,
   output logic [rmvm_pkg::M2_W-1:0]    quot,
   output logic [rmvm_pkg::M2_W-1:0]    prod,
   output logic [rmvm_pkg::DEV_W-1:0]   root
);
   logic                              busy_ff, done_ff, sat_ff;
   rmvm_pkg::alu_op_type              op_ff;
   logic [rmvm_pkg::STEP_W-1:0]       cnt_ff;
   logic [rmvm_pkg::M2_W-1:0]         num_ff;
   logic [rmvm_pkg::REM_W-1:0]        rem_ff;
   logic [rmvm_pkg::ACC_W-1:0]        acc_ff;
   logic [OPA_W-1:0]                  opa_ff;
   logic [COUNT_BITS-1:0]             den_ff;

   logic [rmvm_pkg::REM_W-1:0]        div_r, sq_r, sq_trial;
   logic                              div_ge, sq_ge;
   logic [rmvm_pkg::ACC_W-1:0]        mul_acc;
   logic                              mul_over;

   always_comb begin
      div_r    = {rem_ff[rmvm_pkg::REM_W-2:0], num_ff[rmvm_pkg::M2_W-1]};
      div_ge   = div_r >= rmvm_pkg::REM_W'(den_ff);
      sq_r     = {rem_ff[rmvm_pkg::REM_W-3:0], num_ff[rmvm_pkg::M2_W-1 -: 2]};
      sq_trial = rmvm_pkg::REM_W'({acc_ff[rmvm_pkg::DEV_W-1:0], 2'b01});
      sq_ge    = sq_r >= sq_trial;
      mul_acc  = {acc_ff[rmvm_pkg::ACC_W-2:0], 1'b0}
               + (num_ff[rmvm_pkg::M2_W-1] ? rmvm_pkg::ACC_W'(opa_ff) : '0);
      mul_over = |mul_acc[rmvm_pkg::ACC_W-1:rmvm_pkg::MUL_SAT_BIT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == rmvm_pkg::STEP_W'(1));
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == rmvm_pkg::STEP_W'(1))) begin
            busy_ff <= 1'b0;
         end
      end
      if (cmd.start) begin
         op_ff  <= cmd.op;
         rem_ff <= '0;
         acc_ff <= '0;
         sat_ff <= 1'b0;
         opa_ff <= mcand;
         den_ff <= den;
         case (cmd.op)
            rmvm_pkg::ALU_SQRT: begin
               num_ff <= {opnd[rmvm_pkg::VAR_W-1:0], {(rmvm_pkg::M2_W-rmvm_pkg::VAR_W){1'b0}}};
               cnt_ff <= rmvm_pkg::STEP_W'(rmvm_pkg::SQRT_STEPS);
            end
            rmvm_pkg::ALU_MUL: begin
               num_ff <= opnd;
               cnt_ff <= rmvm_pkg::STEP_W'(rmvm_pkg::MUL_STEPS);
            end
            default: begin
               num_ff <= opnd;
               cnt_ff <= rmvm_pkg::STEP_W'(rmvm_pkg::DIV_STEPS);
            end
         endcase
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - rmvm_pkg::STEP_W'(1);
         case (op_ff)
            rmvm_pkg::ALU_SQRT: begin
               num_ff <= {num_ff[rmvm_pkg::M2_W-3:0], 2'b00};
               if (sq_ge) begin
                  rem_ff <= sq_r - sq_trial;
                  acc_ff <= {acc_ff[rmvm_pkg::ACC_W-2:0], 1'b1};
               end else begin
                  rem_ff <= sq_r;
                  acc_ff <= {acc_ff[rmvm_pkg::ACC_W-2:0], 1'b0};
               end
            end
            rmvm_pkg::ALU_MUL: begin
               num_ff <= {num_ff[rmvm_pkg::M2_W-2:0], 1'b0};
               if (mul_over) begin
                  sat_ff <= 1'b1;
                  acc_ff <= {{(rmvm_pkg::ACC_W-rmvm_pkg::MUL_SAT_BIT-1){1'b0}}, 1'b1,
                             {rmvm_pkg::MUL_SAT_BIT{1'b0}}};
               end else begin
                  acc_ff <= mul_acc;
               end
            end
            default: begin
               num_ff <= {num_ff[rmvm_pkg::M2_W-2:0], div_ge};
               rem_ff <= div_ge ? (div_r - rmvm_pkg::REM_W'(den_ff)) : div_r;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign quot = num_ff;
   assign prod = sat_ff ? '1 : acc_ff[rmvm_pkg::MUL_SAT_BIT-1:rmvm_pkg::MUL_SHIFT];
   assign root = acc_ff[rmvm_pkg::DEV_W-1:0];

endmodule

// File: rtl/running_mean_variance_minmax_core.sv
// Running statistics core: count, min, max, Welford mean and M2, variances, deviations.
// Depends on rmvm_pkg, rmvm_ifs (channels), rmvm_alu and the defines header.
//
// Usage:
//   req_ch carries one item per transfer: mode=1 clears all statistics, mode=0 adds
//   the signed sample. Each item yields exactly one rsp_ch transfer with count,
//   lowest, highest, mean (Q15.16), both variances (Q32.8) and deviations (Q16.4).
//   One bit-serial ALU does every divide, multiply and square root, one bit (or one
//   root digit) per cycle. A sample added runs the mean divide, the M2 multiply,
//   both variance divides and both roots in that order; a clear or a full count
//   runs the variance divides and roots only.
//   req_ch.ready is high only while no item is in work; one item at a time.
//   The response sits in an output register: the next request may be taken while
//   it waits, and that item stalls at its end until rsp_ch.ready drains the register.
//   Reset (synchronous) empties the statistics: count 0, lowest at the largest
//   sample value, highest at the most negative one, mean and M2 zero.
//   When the count is full further samples change nothing and report overflow.
`include "running_mean_variance_minmax_core_defines.svh"
module running_mean_variance_minmax_core #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 16
) (
   input logic           clock,
   input logic           reset,
   rmvm_req_if.sink      req_ch,
   rmvm_rsp_if.source    rsp_ch
);
   localparam int DW = ((SAMPLE_BITS + 16 > 32) ? SAMPLE_BITS + 16 : 32) + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_DIVM_GO, S_DIVM_W, S_MUL_GO, S_MUL_W, S_VB_GO, S_VB_W,
      S_VU_GO, S_VU_W, S_SB_GO, S_SB_W, S_SU_GO, S_SU_W, S_FIN
   } state_type;

   state_type                          state_ff;
   logic [COUNT_BITS-1:0]              count_ff;
   logic signed [SAMPLE_BITS-1:0]      min_ff, max_ff, sample_ff;
   logic signed [31:0]                 mean_ff;
   logic [rmvm_pkg::M2_W-1:0]          m2_ff;
   logic signed [DW-1:0]               delta_ff;
   logic                               zero_term_ff, ovf_ff;
   logic [rmvm_pkg::VAR_W-1:0]         vb_ff, vu_ff;
   logic [rmvm_pkg::DEV_W-1:0]         db_ff, du_ff;

   logic                               rsp_valid_ff, rsp_ovf_ff, rsp_uv_ff;
   logic [COUNT_BITS-1:0]              rsp_count_ff;
   logic signed [SAMPLE_BITS-1:0]      rsp_low_ff, rsp_high_ff;
   logic signed [31:0]                 rsp_mean_ff;
   logic [rmvm_pkg::VAR_W-1:0]         rsp_vu_ff, rsp_vb_ff;
   logic [rmvm_pkg::DEV_W-1:0]         rsp_du_ff, rsp_db_ff;

   rmvm_pkg::alu_cmd_type              alu_cmd;
   logic [rmvm_pkg::M2_W-1:0]          alu_opnd, alu_quot, alu_prod;
   logic [DW-1:0]                      alu_mcand;
   logic [COUNT_BITS-1:0]              alu_den;
   logic                               alu_done;
   logic [rmvm_pkg::DEV_W-1:0]         alu_root;

   logic                               req_fire;
   logic signed [DW-1:0]               xq_in, mean_x, err_in;
   logic [DW-1:0]                      delta_mag, err_mag;
   logic signed [DW:0]                 nm_w;
   logic [DW-1:0]                      q_trunc;
   logic signed [31:0]                 nm_sat;
   logic [rmvm_pkg::M2_W:0]            m2_sum;
   logic [rmvm_pkg::M2_W-1:0]          term;
   logic [rmvm_pkg::VAR_W-1:0]         var_sat;
   logic signed [DW-1:0]               req_xq;
   logic                               out_free;

   always_comb begin
      req_fire  = req_ch.valid && req_ch.ready;
      req_xq    = {{(DW-SAMPLE_BITS-16){req_ch.sample[SAMPLE_BITS-1]}}, req_ch.sample, 16'b0};
      xq_in     = {{(DW-SAMPLE_BITS-16){sample_ff[SAMPLE_BITS-1]}}, sample_ff, 16'b0};
      mean_x    = {{(DW-32){mean_ff[31]}}, mean_ff};
      delta_mag = delta_ff[DW-1] ? DW'(-delta_ff) : DW'(delta_ff);
      q_trunc   = alu_quot[DW-1:0];
      nm_w      = {mean_x[DW-1], mean_x}
                + (delta_ff[DW-1] ? -$signed({1'b0, q_trunc}) : $signed({1'b0, q_trunc}));
      if ((&nm_w[DW:31]) || !(|nm_w[DW:31])) begin
         nm_sat = nm_w[31:0];
      end else if (nm_w[DW]) begin
         nm_sat = {1'b1, 31'b0};
      end else begin
         nm_sat = {1'b0, {31{1'b1}}};
      end
      err_in    = xq_in - mean_x;
      err_mag   = err_in[DW-1] ? DW'(-err_in) : DW'(err_in);
      term      = zero_term_ff ? '0 : alu_prod;
      m2_sum    = {1'b0, m2_ff} + {1'b0, term};
      var_sat   = (|alu_quot[rmvm_pkg::M2_W-1:rmvm_pkg::VAR_W]) ? '1
                : alu_quot[rmvm_pkg::VAR_W-1:0];
      out_free  = !rsp_valid_ff || rsp_ch.ready;

      alu_cmd.start = (state_ff == S_DIVM_GO) || (state_ff == S_MUL_GO)
                   || (state_ff == S_VB_GO) || (state_ff == S_VU_GO)
                   || (state_ff == S_SB_GO) || (state_ff == S_SU_GO);
      alu_opnd  = m2_ff;
      alu_mcand = delta_mag;
      alu_den   = count_ff;
      case (state_ff)
         S_DIVM_GO: begin
            alu_cmd.op = rmvm_pkg::ALU_DIV;
            alu_opnd   = rmvm_pkg::M2_W'(delta_mag);
         end
         S_MUL_GO: begin
            alu_cmd.op = rmvm_pkg::ALU_MUL;
            alu_opnd   = rmvm_pkg::M2_W'(err_mag);
         end
         S_VU_GO: begin
            alu_cmd.op = rmvm_pkg::ALU_DIV;
            alu_den    = count_ff - COUNT_BITS'(1);
         end
         S_SB_GO: begin
            alu_cmd.op = rmvm_pkg::ALU_SQRT;
            alu_opnd   = rmvm_pkg::M2_W'(vb_ff);
         end
         S_SU_GO: begin
            alu_cmd.op = rmvm_pkg::ALU_SQRT;
            alu_opnd   = rmvm_pkg::M2_W'(vu_ff);
         end
         default: begin
            alu_cmd.op = rmvm_pkg::ALU_DIV;
         end
      endcase
   end

   rmvm_alu #(
      .OPA_W      (DW),
      .COUNT_BITS (COUNT_BITS)
   ) u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .opnd  (alu_opnd),
      .mcand (alu_mcand),
      .den   (alu_den),
      .done  (alu_done),
      .quot  (alu_quot),
      .prod  (alu_prod),
      .root  (alu_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         mean_ff      <= '0;
         m2_ff        <= '0;
         min_ff       <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         max_ff       <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         ovf_ff       <= 1'b0;
      end else begin
         if ((state_ff == S_FIN) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  ovf_ff <= 1'b0;
                  if (req_ch.mode) begin
                     count_ff <= '0;
                     mean_ff  <= '0;
                     m2_ff    <= '0;
                     min_ff   <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                     max_ff   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                     state_ff <= S_VB_GO;
                  end else if (&count_ff) begin
                     ovf_ff   <= 1'b1;
                     state_ff <= S_VB_GO;
                  end else begin
                     if (req_ch.sample < min_ff) begin
                        min_ff <= req_ch.sample;
                     end
                     if (req_ch.sample > max_ff) begin
                        max_ff <= req_ch.sample;
                     end
                     count_ff  <= count_ff + COUNT_BITS'(1);
                     sample_ff <= req_ch.sample;
                     delta_ff  <= req_xq - mean_x;
                     state_ff  <= S_DIVM_GO;
                  end
               end
            end
            S_DIVM_GO: state_ff <= S_DIVM_W;
            S_DIVM_W: begin
               if (alu_done) begin
                  mean_ff  <= nm_sat;
                  state_ff <= S_MUL_GO;
               end
            end
            S_MUL_GO: begin
               zero_term_ff <= (delta_ff[DW-1] && !err_in[DW-1] && (|err_in))
                            || (!delta_ff[DW-1] && (|delta_ff) && err_in[DW-1]);
               state_ff <= S_MUL_W;
            end
            S_MUL_W: begin
               if (alu_done) begin
                  m2_ff    <= m2_sum[rmvm_pkg::M2_W] ? '1 : m2_sum[rmvm_pkg::M2_W-1:0];
                  state_ff <= S_VB_GO;
               end
            end
            S_VB_GO: state_ff <= S_VB_W;
            S_VB_W: begin
               if (alu_done) begin
                  vb_ff    <= (count_ff == '0) ? '0 : var_sat;
                  state_ff <= S_VU_GO;
               end
            end
            S_VU_GO: state_ff <= S_VU_W;
            S_VU_W: begin
               if (alu_done) begin
                  vu_ff    <= (count_ff < COUNT_BITS'(2)) ? '0 : var_sat;
                  state_ff <= S_SB_GO;
               end
            end
            S_SB_GO: state_ff <= S_SB_W;
            S_SB_W: begin
               if (alu_done) begin
                  db_ff    <= alu_root;
                  state_ff <= S_SU_GO;
               end
            end
            S_SU_GO: state_ff <= S_SU_W;
            S_SU_W: begin
               if (alu_done) begin
                  du_ff    <= alu_root;
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_count_ff <= count_ff;
                  rsp_low_ff   <= min_ff;
                  rsp_high_ff  <= max_ff;
                  rsp_mean_ff  <= mean_ff;
                  rsp_vu_ff    <= vu_ff;
                  rsp_vb_ff    <= vb_ff;
                  rsp_du_ff    <= du_ff;
                  rsp_db_ff    <= db_ff;
                  rsp_uv_ff    <= count_ff >= COUNT_BITS'(2);
                  rsp_ovf_ff   <= ovf_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.count          = rsp_count_ff;
   assign rsp_ch.lowest         = rsp_low_ff;
   assign rsp_ch.highest        = rsp_high_ff;
   assign rsp_ch.mean           = rsp_mean_ff;
   assign rsp_ch.var_unbiased   = rsp_vu_ff;
   assign rsp_ch.var_biased     = rsp_vb_ff;
   assign rsp_ch.dev_unbiased   = rsp_du_ff;
   assign rsp_ch.dev_biased     = rsp_db_ff;
   assign rsp_ch.unbiased_valid = rsp_uv_ff;
   assign rsp_ch.overflow       = rsp_ovf_ff;

   `RMVM_ASSERT_NEXT(a_clear_empties, clock, reset, req_fire && req_ch.mode,
      count_ff == '0 && m2_ff == '0)
   `RMVM_ASSERT_NOW(a_minmax_order, clock, reset, count_ff != '0, min_ff <= max_ff)
   `RMVM_ASSERT_NOW(a_done_in_wait, clock, reset, alu_done,
      state_ff == S_DIVM_W || state_ff == S_MUL_W || state_ff == S_VB_W ||
      state_ff == S_VU_W || state_ff == S_SB_W || state_ff == S_SU_W)
   `RMVM_ASSERT_NOW(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_FIN)

endmodule
